>>> src/dbar_pkg.sv
`timescale 1ns / 1ps

package dbar_pkg;

  // Counter width of the debounce, hold and repeat timers.
  localparam int TIMER_WIDTH = 16;
  localparam int PERIOD_WIDTH = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int STEP_WIDTH = 8;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  typedef logic [TIMER_WIDTH-1:0] timer_count_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_DEBOUNCE_TICKS = 3'd0,
    CFG_HOLD_TICKS     = 3'd1,
    CFG_REPEAT_TICKS   = 3'd2,
    CFG_STEP_AMOUNT    = 3'd3,
    CFG_MIN_VALUE      = 3'd4,
    CFG_MAX_VALUE      = 3'd5
  } cfg_index_t;

  // Per-timer commands from the control logic.
  typedef struct packed {
    logic start;
    logic stop;
  } timer_ctrl_t;

  // Period to load: zero counts as one, saturate at the counter maximum.
  function automatic timer_count_t timer_load(input logic [PERIOD_WIDTH-1:0] period);
    logic [32:0] p;
    p = 33'(period);
    if (p == 33'd0) begin
      p = 33'd1;
    end
    if (p > TIMER_MAX) begin
      p = TIMER_MAX;
    end
    return p[TIMER_WIDTH-1:0];
  endfunction

endpackage

>>> src/debounced_button_auto_repeat.sv
`timescale 1ns / 1ps

// Debounced push button with auto-repeat. Each input transaction is one tick carrying the
// sampled button level and the present parameter value; each tick yields exactly one output
// transaction with the (possibly stepped) value and an action flag. A press latches and starts
// the debounce timer; if still held at its expiry the value is stepped and the hold timer
// starts; at hold expiry the value is stepped again and the repeat timer runs, stepping on
// every expiry until release, which clears everything. A positive step is applied only if the
// result stays <= max_value, a negative one only if it stays >= min_value; the action is
// flagged even when refused. Period registers of zero act as one. Throughput is one tick per
// clock: timer expiry and the bound check are combinational and the output register takes
// the result in the same edge that accepts the tick, so in_ready stays high unless a held
// result is not being taken. Write configuration only while no transaction is in flight.

module debounced_button_auto_repeat import dbar_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       button_down,
  input  logic [VALUE_WIDTH-1:0]     current_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VALUE_WIDTH-1:0]     new_value,
  output logic                       action_taken
);

  // Configuration registers.
  logic [PERIOD_WIDTH-1:0] debounce_ticks;
  logic [PERIOD_WIDTH-1:0] hold_ticks;
  logic [PERIOD_WIDTH-1:0] repeat_ticks;
  logic [STEP_WIDTH-1:0]   step_amount;
  logic [VALUE_WIDTH-1:0]  min_value;
  logic [VALUE_WIDTH-1:0]  max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= PERIOD_WIDTH'(50);
      hold_ticks <= PERIOD_WIDTH'(500);
      repeat_ticks <= PERIOD_WIDTH'(100);
      step_amount <= STEP_WIDTH'(1);
      min_value <= '0;
      max_value <= '1;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[PERIOD_WIDTH-1:0];
        CFG_HOLD_TICKS:     hold_ticks <= cfg_data[PERIOD_WIDTH-1:0];
        CFG_REPEAT_TICKS:   repeat_ticks <= cfg_data[PERIOD_WIDTH-1:0];
        CFG_STEP_AMOUNT:    step_amount <= cfg_data[STEP_WIDTH-1:0];
        CFG_MIN_VALUE:      min_value <= cfg_data[VALUE_WIDTH-1:0];
        CFG_MAX_VALUE:      max_value <= cfg_data[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: take a tick whenever the output register is free or being drained.
  logic accept;
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  // Tick control.
  logic        press_latched;
  logic        press_latched_next;
  logic        deb_exp;
  logic        hold_exp;
  logic        rep_exp;
  logic        start_press;
  logic        first_step;
  logic        release_press;
  logic        repeat_step;
  logic        do_step;
  timer_ctrl_t deb_ctrl;
  timer_ctrl_t hold_ctrl;
  timer_ctrl_t rep_ctrl;

  // First matching rule wins: new press, debounce step, release, repeat step.
  assign start_press = button_down && !press_latched;
  assign first_step = press_latched && button_down && deb_exp;
  assign release_press = press_latched && !button_down;
  assign repeat_step = press_latched && button_down && !deb_exp && (hold_exp || rep_exp);
  assign do_step = first_step || repeat_step;

  assign deb_ctrl = '{start: start_press, stop: release_press};
  assign hold_ctrl = '{start: first_step, stop: release_press};
  assign rep_ctrl = '{start: repeat_step, stop: release_press};

  always_comb begin
    press_latched_next = press_latched;
    if (start_press) begin
      press_latched_next = 1'b1;
    end else if (release_press) begin
      press_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_latched <= 1'b0;
    end else if (accept) begin
      press_latched <= press_latched_next;
    end
  end

  dbar_timer u_debounce_timer (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .ctrl    (deb_ctrl),
    .period  (debounce_ticks),
    .expired (deb_exp)
  );

  dbar_timer u_hold_timer (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .ctrl    (hold_ctrl),
    .period  (hold_ticks),
    .expired (hold_exp)
  );

  dbar_timer u_repeat_timer (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .ctrl    (rep_ctrl),
    .period  (repeat_ticks),
    .expired (rep_exp)
  );

  // Bounded step of the incoming value.
  logic [VALUE_WIDTH-1:0] stepped;

  dbar_step u_step (
    .value       (current_value),
    .step_amount (step_amount),
    .min_value   (min_value),
    .max_value   (max_value),
    .stepped     (stepped)
  );

  // Output register: load on accept, drop valid once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      new_value <= do_step ? stepped : current_value;
      action_taken <= do_step;
    end
  end

endmodule

>>> src/dbar_timer.sv
`timescale 1ns / 1ps

module dbar_timer import dbar_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  timer_ctrl_t             ctrl,
  input  logic [PERIOD_WIDTH-1:0] period,
  output logic                    expired
);

  timer_count_t left;
  timer_count_t left_next;
  logic         running;
  logic         running_next;

  // Expiry of the tick being taken, seen before the count moves.
  assign expired = running && (left <= timer_count_t'(1));

  always_comb begin
    left_next = left;
    running_next = running;
    if (ctrl.start) begin
      left_next = timer_load(period);
      running_next = 1'b1;
    end else if (ctrl.stop || expired) begin
      left_next = '0;
      running_next = 1'b0;
    end else if (running) begin
      left_next = left - timer_count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      running <= 1'b0;
    end else if (advance) begin
      left <= left_next;
      running <= running_next;
    end
  end

endmodule

>>> src/dbar_step.sv
`timescale 1ns / 1ps

module dbar_step import dbar_pkg::*; (
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [STEP_WIDTH-1:0]  step_amount,
  input  logic [VALUE_WIDTH-1:0] min_value,
  input  logic [VALUE_WIDTH-1:0] max_value,
  output logic [VALUE_WIDTH-1:0] stepped
);

  localparam int W = VALUE_WIDTH + 2;

  logic signed [W-1:0] v;
  logic signed [W-1:0] s;
  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W-1:0] sum;
  logic                ok;

  assign v = $signed({2'b00, value});
  assign s = W'($signed(step_amount));
  assign lo = $signed({2'b00, min_value}) - s;
  assign hi = $signed({2'b00, max_value}) - s;
  assign sum = v + s;

  // Positive step only below the ceiling, negative only above the floor.
  assign ok = (s > 0 && hi >= v) || (s < 0 && lo <= v);
  assign stepped = ok ? sum[VALUE_WIDTH-1:0] : value;

endmodule

>>> tb/sv/button_repeat_checker.sv
`timescale 1ns / 1ps

// Watches the tick and result channels of the auto-repeat button block and
// keeps its own copy of the timers, the latch and the registers. Each accepted
// tick is turned into the result it must produce. Results come back in order
// and are compared against the oldest one waiting.
module button_repeat_checker import dbar_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       button_down,
  input  logic [VALUE_WIDTH-1:0]     current_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [VALUE_WIDTH-1:0]     new_value,
  input  logic                       action_taken,
  output int                         fail_count,
  output int                         pending,
  output int                         checked,
  output int                         steps
);

  localparam int TMR_DEBOUNCE = 0;
  localparam int TMR_HOLD     = 1;
  localparam int TMR_REPEAT   = 2;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   action;
  } tick_result_t;

  tick_result_t tick_results_q[$];

  logic [PERIOD_WIDTH-1:0]      debounce_cfg;
  logic [PERIOD_WIDTH-1:0]      hold_cfg;
  logic [PERIOD_WIDTH-1:0]      repeat_cfg;
  logic signed [STEP_WIDTH-1:0] step_cfg;
  logic [VALUE_WIDTH-1:0]       min_cfg;
  logic [VALUE_WIDTH-1:0]       max_cfg;

  logic                   latched;
  logic [TIMER_WIDTH-1:0] tmr_left [3];
  logic                   tmr_run  [3];

  initial begin
    fail_count = 0;
    checked    = 0;
    steps      = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at result %0d: %s", checked, what);
    fail_count++;
  endtask

  // Advance one timer by a tick; true on the tick it runs out.
  function automatic logic count_down(input int k);
    if (!tmr_run[k]) begin
      return 1'b0;
    end
    if (tmr_left[k] <= 1) begin
      tmr_left[k] = '0;
      tmr_run[k]  = 1'b0;
      return 1'b1;
    end
    tmr_left[k] = tmr_left[k] - 1'b1;
    return 1'b0;
  endfunction

  function automatic void start_timer(input int k, input logic [PERIOD_WIDTH-1:0] period);
    logic [32:0] n;
    n = 33'(period);
    if (n == 33'd0) begin
      n = 33'd1;
    end
    if (n > TIMER_MAX) begin
      n = TIMER_MAX;
    end
    tmr_left[k] = n[TIMER_WIDTH-1:0];
    tmr_run[k]  = 1'b1;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] step_value(input logic [VALUE_WIDTH-1:0] value);
    int v;
    int s;
    v = value;
    s = step_cfg;
    if ((s > 0 && int'(max_cfg) - s >= v) || (s < 0 && int'(min_cfg) - s <= v)) begin
      v = v + s;
    end
    return v[VALUE_WIDTH-1:0];
  endfunction

  function automatic tick_result_t predict_tick(input logic down,
                                                input logic [VALUE_WIDTH-1:0] value);
    tick_result_t r;
    logic         deb_done;
    logic         hold_done;
    logic         rep_done;
    int           k;
    deb_done  = count_down(TMR_DEBOUNCE);
    hold_done = count_down(TMR_HOLD);
    rep_done  = count_down(TMR_REPEAT);
    r.value   = value;
    r.action  = 1'b0;
    if (down && !latched) begin
      latched = 1'b1;
      start_timer(TMR_DEBOUNCE, debounce_cfg);
    end else if (latched && down && deb_done) begin
      r.action = 1'b1;
      r.value  = step_value(value);
      start_timer(TMR_HOLD, hold_cfg);
    end else if (latched && !down) begin
      latched = 1'b0;
      for (k = 0; k < 3; k++) begin
        tmr_left[k] = '0;
        tmr_run[k]  = 1'b0;
      end
    end else if (latched && down && (hold_done || rep_done)) begin
      r.action = 1'b1;
      r.value  = step_value(value);
      start_timer(TMR_REPEAT, repeat_cfg);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    int           k;
    if (rst) begin
      debounce_cfg = 16'd50;
      hold_cfg     = 16'd500;
      repeat_cfg   = 16'd100;
      step_cfg     = 8'sd1;
      min_cfg      = 16'h0000;
      max_cfg      = 16'hFFFF;
      latched      = 1'b0;
      for (k = 0; k < 3; k++) begin
        tmr_left[k] = '0;
        tmr_run[k]  = 1'b0;
      end
      tick_results_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_DEBOUNCE_TICKS: debounce_cfg = cfg_data;
          CFG_HOLD_TICKS:     hold_cfg     = cfg_data;
          CFG_REPEAT_TICKS:   repeat_cfg   = cfg_data;
          CFG_STEP_AMOUNT:    step_cfg     = cfg_data[STEP_WIDTH-1:0];
          CFG_MIN_VALUE:      min_cfg      = cfg_data;
          CFG_MAX_VALUE:      max_cfg      = cfg_data;
          default: ;
        endcase
      end
      // A result leaving now belongs to a tick taken at an earlier edge.
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with no tick waiting",
                                    new_value, action_taken));
        end else begin
          want = tick_results_q.pop_front();
          if (new_value !== want.value) begin
            report_mismatch($sformatf("new_value %h, want %h", new_value, want.value));
          end
          if (action_taken !== want.action) begin
            report_mismatch($sformatf("action_taken %b, want %b", action_taken, want.action));
          end
          if (want.action) begin
            steps++;
          end
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        tick_results_q.push_back(predict_tick(button_down, current_value));
      end
    end
    pending <= tick_results_q.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the auto-repeat button bench: makes ticks and register settings,
// toggles ready on the result side, and gives the verdict from the checker's
// failure count.
module tb;
  import dbar_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       button_down = 1'b0;
  logic [VALUE_WIDTH-1:0]     current_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [VALUE_WIDTH-1:0]     new_value;
  logic                       action_taken;

  int fail_count;
  int pending;
  int checked;
  int steps;

  // Idle rates in percent of cycles for each side.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Local copy of the registers, only used to shape the stimulus.
  logic [PERIOD_WIDTH-1:0] cur_deb;
  logic [PERIOD_WIDTH-1:0] cur_hold;
  logic [PERIOD_WIDTH-1:0] cur_rep;
  logic [VALUE_WIDTH-1:0]  cur_min;
  logic [VALUE_WIDTH-1:0]  cur_max;
  int                      n_settings = 0;

  always #5 clk = ~clk;

  debounced_button_auto_repeat u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_down   (button_down),
    .current_value (current_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_value     (new_value),
    .action_taken  (action_taken)
  );

  button_repeat_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_down   (button_down),
    .current_value (current_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_value     (new_value),
    .action_taken  (action_taken),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .steps         (steps)
  );

  // Receiver side: drop ready at the current idle rate, one decision per edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Present one tick and hold it until the transaction is taken. Idle cycles
  // go before the tick so gaps land on every phase of a press.
  task automatic send_tick(input logic down, input logic [VALUE_WIDTH-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    button_down   <= down;
    current_value <= value;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every tick has come back, plus a short margin.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Write all six registers back to back, one per edge, then drop the enable.
  task automatic set_config(input logic [PERIOD_WIDTH-1:0] deb,
                            input logic [PERIOD_WIDTH-1:0] hold,
                            input logic [PERIOD_WIDTH-1:0] rep,
                            input logic [STEP_WIDTH-1:0]   step,
                            input logic [VALUE_WIDTH-1:0]  minv,
                            input logic [VALUE_WIDTH-1:0]  maxv);
    logic [CFG_DATA_WIDTH-1:0] vals [6];
    cfg_index_t                idxs [6];
    int                        k;
    vals[0] = deb;  idxs[0] = CFG_DEBOUNCE_TICKS;
    vals[1] = hold; idxs[1] = CFG_HOLD_TICKS;
    vals[2] = rep;  idxs[2] = CFG_REPEAT_TICKS;
    vals[3] = CFG_DATA_WIDTH'(step); idxs[3] = CFG_STEP_AMOUNT;
    vals[4] = minv; idxs[4] = CFG_MIN_VALUE;
    vals[5] = maxv; idxs[5] = CFG_MAX_VALUE;
    for (k = 0; k < 6; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_deb  = deb;
    cur_hold = hold;
    cur_rep  = rep;
    cur_min  = minv;
    cur_max  = maxv;
    n_settings++;
  endtask

  function automatic int period_eff(input logic [PERIOD_WIDTH-1:0] p);
    return (p == 0) ? 1 : int'(p);
  endfunction

  // Mostly short periods so presses get deep into auto-repeat; now and then
  // zero (acts as one) or a somewhat longer one.
  function automatic logic [PERIOD_WIDTH-1:0] rand_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PERIOD_WIDTH'($urandom_range(7, 20));
      default: return PERIOD_WIDTH'($urandom_range(1, 5));
    endcase
  endfunction

  // Values cluster near the bounds so that both accepted and refused steps
  // show up often.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(5))
      0, 1:    return VALUE_WIDTH'($urandom_range(65535));
      2:       return cur_max - VALUE_WIDTH'($urandom_range(130));
      3:       return cur_min + VALUE_WIDTH'($urandom_range(130));
      4:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return cur_max + VALUE_WIDTH'($urandom_range(3));
    endcase
  endfunction

  task automatic randomize_config();
    logic [STEP_WIDTH-1:0]  step;
    logic [VALUE_WIDTH-1:0] minv;
    logic [VALUE_WIDTH-1:0] maxv;
    logic [VALUE_WIDTH-1:0] mid;
    case ($urandom_range(5))
      3:       step = 8'h01;
      4:       step = 8'hFF;
      5:       step = 8'h00;
      default: step = STEP_WIDTH'($urandom_range(255));
    endcase
    case ($urandom_range(2))
      0: begin
        minv = 16'h0000;
        maxv = 16'hFFFF;
      end
      1: begin
        minv = VALUE_WIDTH'($urandom_range(65535));
        maxv = VALUE_WIDTH'($urandom_range(65535));
      end
      default: begin
        mid  = VALUE_WIDTH'($urandom_range(65535));
        minv = mid - VALUE_WIDTH'($urandom_range(300));
        maxv = mid + VALUE_WIDTH'($urandom_range(300));
      end
    endcase
    set_config(rand_period(), rand_period(), rand_period(), step, minv, maxv);
  endtask

  // Mostly presses, each followed by a release, half of them sized to reach
  // the repeat steps; the rest is bounce noise.
  task automatic random_phase(input int n_ticks);
    int sent;
    int full;
    int len;
    int k;
    randomize_config();
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(9) < 8) begin
        full = period_eff(cur_deb) + period_eff(cur_hold)
             + period_eff(cur_rep) * $urandom_range(1, 4) + $urandom_range(1);
        if (full > 60) begin
          full = 60;
        end
        len = $urandom_range(1) ? full : $urandom_range(1, full);
        for (k = 0; k < len; k++) begin
          send_tick(1'b1, pick_value());
        end
        sent += len;
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          send_tick(1'b0, pick_value());
        end
        sent += len;
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          send_tick(1'($urandom_range(1)), pick_value());
        end
        sent += len;
      end
    end
    settle();
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    tx_idle_pct = 21;
    rx_idle_pct = 74;

    // Short periods, largest positive step, full value range.
    set_config(16'd2, 16'd3, 16'd1, 8'h7F, 16'h0000, 16'hFFFF);
    send_tick(1'b0, 16'h1234);  // release with nothing latched: no action
    send_tick(1'b1, 16'hFFFF);  // latch, debounce starts
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF);  // debounce runs out: step refused at the top
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h0000);  // hold runs out: step from zero
    send_tick(1'b1, 16'hFF80);  // repeat: lands exactly on max
    send_tick(1'b1, 16'hFF81);  // repeat: one past, refused
    send_tick(1'b0, 16'h8000);  // release clears everything
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b1, 16'h0001);  // bounce: press then release before debounce
    send_tick(1'b0, 16'h0002);
    settle();

    // Zero periods act as one; most negative step against a raised floor.
    set_config(16'd0, 16'd0, 16'd0, 8'h80, 16'h0100, 16'h8000);
    send_tick(1'b1, 16'h0180);
    send_tick(1'b1, 16'h0180);  // step down lands exactly on min
    send_tick(1'b1, 16'h0100);  // refused below min
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b0, 16'h0000);
    settle();

    random_phase(185);
    random_phase(185);

    // Now the sender idles heavily and the receiver lightly.
    tx_idle_pct = 74;
    rx_idle_pct = 21;

    // Widest periods and crossed bounds: nothing expires, nothing steps.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 16'hFFFF, 16'h0000);
    for (k = 0; k < 30; k++) begin
      send_tick(k < 26, pick_value());
    end
    settle();

    random_phase(185);
    random_phase(185);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(185);
    random_phase(185);

    repeat (10) @(posedge clk);
    $display("Checked %0d ticks, %0d of them steps, over %0d register settings",
             checked, steps, n_settings);
    $display("with sender-heavy, receiver-heavy and no idling, periods from 0 to 65535.");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
